// ----- rtl/core/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Input word kinds carried on in_tuser.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam int COORD_W  = 15;
  localparam int POS_W    = 16;
  localparam int ERR_W    = 17;
  localparam int COLOR_W  = 16;
  localparam int SCREEN_W = 14;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 14'd320;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 14'd480;

  // Line parameters after axis swap and endpoint ordering.
  typedef struct packed {
    logic                    steep;
    logic signed [POS_W-1:0] major_start;
    logic signed [POS_W-1:0] minor_start;
    logic signed [POS_W-1:0] major_end;
    logic [POS_W-1:0]        delta_major;
    logic [POS_W-1:0]        delta_minor;
    logic                    minor_down;
  } line_setup_t;

endpackage

// ----- rtl/core/lr_setup.sv -----
// ----------------------------------------------------------------------------
// lr_setup
// Turns two endpoints into major/minor axis form for the step engine.
// ----------------------------------------------------------------------------
module lr_setup
  import lr_pkg::*;
(
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] y_start,
  input  logic signed [COORD_W-1:0] x_stop,
  input  logic signed [COORD_W-1:0] y_stop,
  output line_setup_t               setup
);

  logic signed [POS_W-1:0] x0, y0, x1, y1;
  logic signed [POS_W-1:0] dx, dy;
  logic [POS_W-1:0]        adx, ady;
  logic                    steep;
  logic signed [POS_W-1:0] a0, b0, a1, b1;
  logic signed [POS_W-1:0] ma0, mb0, ma1, mb1;
  logic signed [POS_W-1:0] db;

  always_comb begin
    x0 = POS_W'(x_start);
    y0 = POS_W'(y_start);
    x1 = POS_W'(x_stop);
    y1 = POS_W'(y_stop);
    dx = x1 - x0;
    dy = y1 - y0;
    adx = dx[POS_W-1] ? POS_W'(-dx) : POS_W'(dx);
    ady = dy[POS_W-1] ? POS_W'(-dy) : POS_W'(dy);
    steep = ady > adx;
    a0 = steep ? y0 : x0;
    b0 = steep ? x0 : y0;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    // Order the endpoints so that the major coordinate rises.
    if (a0 > a1) begin
      ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
    end else begin
      ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
    end
    db = mb1 - mb0;
    setup.steep       = steep;
    setup.major_start = ma0;
    setup.minor_start = mb0;
    setup.major_end   = ma1;
    setup.delta_major = POS_W'(ma1 - ma0);
    setup.delta_minor = db[POS_W-1] ? POS_W'(-db) : POS_W'(db);
    setup.minor_down  = !(mb0 < mb1);
  end

endmodule

// ----- rtl/core/line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line engine: one pixel word per start word and per step word in a line.
// ----------------------------------------------------------------------------
// A start word (in_tuser low) carries two endpoints and a color and yields the
// first pixel of the line; each step word (in_tuser high) yields the next pixel
// by the integer Bresenham rule, and a step with no line in progress yields
// nothing. Both endpoints are drawn, and the final pixel carries out_tlast.
// Each pixel is flagged visible when 0 <= x < screen_width and
// 0 <= y < screen_height; off-screen pixels are still delivered with the flag
// low. The block takes one word per clock when not stalled: the endpoint
// setup (axis swap, ordering, deltas) is done ahead of the input register,
// and the single Bresenham step (one subtract, one add and a compare) runs
// between the input and output registers, so throughput is one pixel per cycle.
// Backpressure on out_tready stalls the input side only when the output
// register is full and the held word would produce a pixel. The user must write
// configuration registers only while the block is idle; it is not enforced.
module line_rasterizer
  import lr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [SCREEN_W-1:0]   cfg_wdata,
  // Input words.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [14:0] x_start, [29:15] y_start, [44:30] x_stop, [59:45] y_stop,
  // [75:60] pixel_color, [79:76] zero.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode.
  input  logic                  in_tuser,
  // Pixel words.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [14:0] pixel_x, [29:15] pixel_y, [45:30] out_color, [46] visible,
  // [47] zero.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] last.
  output logic                  out_tlast
);

  // Screen size registers.
  logic [SCREEN_W-1:0] screen_width_r, screen_height_r;

  // Input register, with the line setup already worked out.
  logic                 s_valid_r;
  logic                 s_mode_r;
  line_setup_t          s_setup_r;
  logic [COLOR_W-1:0]   s_color_r;
  line_setup_t          setup;

  // Line state.
  logic                    active_r;
  logic                    steep_r;
  logic signed [POS_W-1:0] major_pos_r;
  logic signed [POS_W-1:0] minor_pos_r;
  logic signed [POS_W-1:0] major_end_r;
  logic signed [ERR_W-1:0] error_term_r;
  logic [POS_W-1:0]        delta_major_r;
  logic [POS_W-1:0]        delta_minor_r;
  logic                    minor_down_r;
  logic [COLOR_W-1:0]      line_color_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  // Working values of the step stage.
  logic                    cur_steep;
  logic signed [POS_W-1:0] cur_major, cur_minor, cur_end;
  logic signed [ERR_W-1:0] cur_err;
  logic [POS_W-1:0]        cur_dmaj, cur_dmin;
  logic                    cur_down;
  logic [COLOR_W-1:0]      cur_color;
  logic signed [POS_W-1:0] px, py;
  logic                    px_vis, py_vis, vis, fin;
  logic signed [ERR_W-1:0] err_dec;
  logic signed [ERR_W-1:0] error_term_nxt;
  logic signed [POS_W-1:0] minor_pos_nxt;
  logic [OUT_DATA_W-1:0]   out_data_nxt;

  logic produce, out_free, advance, fire;

  lr_setup u_setup (
    .x_start (in_tdata[14:0]),
    .y_start (in_tdata[29:15]),
    .x_stop  (in_tdata[44:30]),
    .y_stop  (in_tdata[59:45]),
    .setup   (setup)
  );

  // A start always yields a pixel; a step only while a line is in progress.
  assign produce   = (s_mode_r == MODE_START) || active_r;
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s_valid_r && (out_free || !produce);
  assign fire      = advance && produce;
  assign in_tready = !s_valid_r || advance;

  always_comb begin
    if (s_mode_r == MODE_START) begin
      cur_steep = s_setup_r.steep;
      cur_major = s_setup_r.major_start;
      cur_minor = s_setup_r.minor_start;
      cur_end   = s_setup_r.major_end;
      cur_err   = ERR_W'(s_setup_r.delta_major >> 1);
      cur_dmaj  = s_setup_r.delta_major;
      cur_dmin  = s_setup_r.delta_minor;
      cur_down  = s_setup_r.minor_down;
      cur_color = s_color_r;
    end else begin
      cur_steep = steep_r;
      cur_major = major_pos_r;
      cur_minor = minor_pos_r;
      cur_end   = major_end_r;
      cur_err   = error_term_r;
      cur_dmaj  = delta_major_r;
      cur_dmin  = delta_minor_r;
      cur_down  = minor_down_r;
      cur_color = line_color_r;
    end

    px = cur_steep ? cur_minor : cur_major;
    py = cur_steep ? cur_major : cur_minor;
    // Coordinates stay within 15 signed bits, so the low 15 bits compare exactly.
    px_vis = !px[POS_W-1] && (px[COORD_W-1:0] < {1'b0, screen_width_r});
    py_vis = !py[POS_W-1] && (py[COORD_W-1:0] < {1'b0, screen_height_r});
    vis    = px_vis && py_vis;
    fin    = cur_major >= cur_end;

    err_dec = cur_err - $signed({1'b0, cur_dmin});
    if (err_dec < 0) begin
      error_term_nxt = err_dec + $signed({1'b0, cur_dmaj});
      minor_pos_nxt  = cur_down ? cur_minor - 16'sd1 : cur_minor + 16'sd1;
    end else begin
      error_term_nxt = err_dec;
      minor_pos_nxt  = cur_minor;
    end

    out_data_nxt = {1'b0, vis, cur_color, py[COORD_W-1:0], px[COORD_W-1:0]};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      s_valid_r       <= 1'b0;
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
          CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tready) begin
        s_valid_r <= in_tvalid;
      end
      if (fire) begin
        active_r <= !fin;
      end
      if (out_free) begin
        out_valid_r <= fire;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_mode_r  <= in_tuser;
      s_setup_r <= setup;
      s_color_r <= in_tdata[75:60];
    end
    if (fire) begin
      steep_r       <= cur_steep;
      major_pos_r   <= cur_major + 16'sd1;
      minor_pos_r   <= minor_pos_nxt;
      major_end_r   <= cur_end;
      error_term_r  <= error_term_nxt;
      delta_major_r <= cur_dmaj;
      delta_minor_r <= cur_dmin;
      minor_down_r  <= cur_down;
      line_color_r  <= cur_color;
      out_data_r    <= out_data_nxt;
      out_last_r    <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/lr_checker.sv -----
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker
  import lr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // A stalled pixel word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("pixel word changed while stalled");

  // No pixel right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pixel word valid after reset");

  // A visible pixel never has a negative coordinate.
  a_visible_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[46] || (!out_tdata[14] && !out_tdata[29]))
    else $error("visible pixel with negative coordinate");

  // With the output register empty, the input side is never stalled.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/line_rasterizer_tb.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// Self-checking bench for the Bresenham line engine.
// ----------------------------------------------------------------------------
// A queue of start and step words feeds a clocked driver. A clocked monitor
// runs each accepted word through a local line tracer, which keeps its own copy
// of the line state and the screen size. It then checks every pixel word that
// leaves the block against the oldest pixel still due. A directed opening is
// followed by random phases. Each phase uses its own screen size and a
// mix of sender gaps and receiver stalls.
module line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  // Cycles with no word moving on either side before the run is abandoned.
  // The worst correct case is a receiver held off at random half of the time,
  // so quiet stretches stay short. The limit sits far above that.
  localparam int STALL_LIMIT = 2000;

  // One word on the input side, unpacked. Step words from queue_line carry
  // random payload that the block must ignore.
  typedef struct {
    logic                      mode;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
    logic [COLOR_W-1:0]        color;
  } draw_word_t;

  // One pixel word on the output side, unpacked.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      vis;
    logic                      last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_addr = CFG_SCREEN_WIDTH;
  logic [SCREEN_W-1:0]   cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [14:0] x_start, [29:15] y_start, [44:30] x_stop, [59:45] y_stop,
  // [75:60] pixel_color, [79:76] zero.
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] mode.
  logic                  in_tuser = MODE_STEP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [14:0] pixel_x, [29:15] pixel_y, [45:30] out_color, [46] visible,
  // [47] zero.
  logic [OUT_DATA_W-1:0] out_tdata;
  // [0] last.
  logic                  out_tlast;

  line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line tracer: the bench's own copy of the screen size and the line state.
  // --------------------------------------------------------------------------
  logic [SCREEN_W-1:0]     scr_w = SCREEN_WIDTH_RST;
  logic [SCREEN_W-1:0]     scr_h = SCREEN_HEIGHT_RST;
  logic                    line_busy = 1'b0;
  logic                    steep = 1'b0;
  logic                    minor_dn = 1'b0;
  logic signed [POS_W-1:0] maj = '0;
  logic signed [POS_W-1:0] mnr = '0;
  logic signed [POS_W-1:0] maj_end = '0;
  logic signed [POS_W-1:0] d_maj = '0;
  logic signed [POS_W-1:0] d_mnr = '0;
  logic signed [ERR_W-1:0] err = '0;
  logic [COLOR_W-1:0]      line_rgb = '0;

  // Pixels that the block owes us, oldest first.
  pixel_t pixels_due[$];

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Number of steps after the first pixel, i.e. the length along the major axis.
  function automatic int line_length(int x0, int y0, int x1, int y1);
    return (abs_diff(y0, y1) > abs_diff(x0, x1)) ? abs_diff(y0, y1) : abs_diff(x0, x1);
  endfunction

  // Emit the pixel at the current position, then, unless it is the last, move one step along the line.
  task automatic emit_pixel();
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    pixel_t                  p;
    px = steep ? mnr : maj;
    py = steep ? maj : mnr;
    p.x     = px[COORD_W-1:0];
    p.y     = py[COORD_W-1:0];
    p.color = line_rgb;
    p.vis   = (px >= 0) && (py >= 0) &&
              (px < $signed({2'b00, scr_w})) && (py < $signed({2'b00, scr_h}));
    p.last  = (maj >= maj_end);
    pixels_due.push_back(p);
    line_busy = !p.last;
    if (!p.last) begin
      err = err - d_mnr;
      if (err < 0) begin
        mnr = minor_dn ? mnr - 16'sd1 : mnr + 16'sd1;
        err = err + d_maj;
      end
      maj = maj + 16'sd1;
    end
  endtask

  // Apply one accepted input word to the tracer.
  task automatic trace_word(draw_word_t w);
    int x0, y0, x1, y1;
    int a0, b0, a1, b1, t;
    if (w.mode == MODE_START) begin
      x0 = w.xs;
      y0 = w.ys;
      x1 = w.xe;
      y1 = w.ye;
      // Steep lines walk along y, so swap the roles of the axes.
      steep = abs_diff(y0, y1) > abs_diff(x0, x1);
      if (steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      // Always walk with the major coordinate rising.
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      maj      = POS_W'(a0);
      mnr      = POS_W'(b0);
      maj_end  = POS_W'(a1);
      d_maj    = POS_W'(a1 - a0);
      d_mnr    = POS_W'(abs_diff(b1, b0));
      err      = ERR_W'((a1 - a0) / 2);
      minor_dn = !(b0 < b1);
      line_rgb = w.color;
      emit_pixel();
    end else if (line_busy) begin
      emit_pixel();
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: words leave the queue at the falling edge.
  // --------------------------------------------------------------------------
  draw_word_t draw_q[$];
  draw_word_t drive_word;
  bit         in_fire = 1'b0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      // A new word goes up only once the current one has been taken.
      if (!in_tvalid || in_fire) begin
        if (draw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_word = draw_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drive_word.mode;
          in_tdata  <= {4'b0000, drive_word.color, drive_word.ye, drive_word.xe,
                        drive_word.ys, drive_word.xs};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge.
  // --------------------------------------------------------------------------
  int mismatches = 0;
  int quiet_cycles = 0;

  task automatic note_mismatch(string why, pixel_t want, pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: want x=%0d y=%0d color=%h vis=%b last=%b, ",
                "got x=%0d y=%0d color=%h vis=%b last=%b"},
               $realtime, why, want.x, want.y, want.color, want.vis, want.last,
               got.x, got.y, got.color, got.vis, got.last);
  endtask

  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    bit     moved;
    in_fire = 1'b0;
    moved   = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved     = 1'b1;
        got.x     = out_tdata[14:0];
        got.y     = out_tdata[29:15];
        got.color = out_tdata[45:30];
        got.vis   = out_tdata[46];
        got.last  = out_tlast;
        if (pixels_due.size() == 0) begin
          want = '{default: '0};
          note_mismatch("pixel with nothing due", want, got);
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.vis !== want.vis || got.last !== want.last)
            note_mismatch("pixel mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        moved   = 1'b1;
        in_fire = 1'b1;
        trace_word(drive_word);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("line_rasterizer test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int items_queued = 0;

  function automatic int clamp_coord(int v);
    if (v > 16383)
      return 16383;
    if (v < -16384)
      return -16384;
    return v;
  endfunction

  // Queue a start word and a run of step words. Only steps that still land on
  // the line count as items; the rest exercise the idle step case.
  task automatic queue_line(int xs, int ys, int xe, int ye, int color, int nsteps);
    draw_word_t w;
    int         len;
    w.mode  = MODE_START;
    w.xs    = COORD_W'(xs);
    w.ys    = COORD_W'(ys);
    w.xe    = COORD_W'(xe);
    w.ye    = COORD_W'(ye);
    w.color = COLOR_W'(color);
    draw_q.push_back(w);
    len = line_length(xs, ys, xe, ye);
    items_queued += 1 + ((nsteps < len) ? nsteps : len);
    repeat (nsteps) begin
      w.mode  = MODE_STEP;
      w.xs    = COORD_W'($urandom);
      w.ys    = COORD_W'($urandom);
      w.xe    = COORD_W'($urandom);
      w.ye    = COORD_W'($urandom);
      w.color = COLOR_W'($urandom);
      draw_q.push_back(w);
    end
  endtask

  // Most lines are short and start on the screen or just past its edges so that
  // visibility flips often; some hug the coordinate limits, a few span the whole
  // range and get cut short by the next start.
  task automatic queue_random_line();
    int pick, reach, len, n;
    int x0, y0, x1, y1;
    pick = $urandom_range(99);
    if (pick < 80) begin
      x0    = int'($urandom_range(scr_w + 16)) - 8;
      y0    = int'($urandom_range(scr_h + 16)) - 8;
      reach = ($urandom_range(4) == 0) ? 40 : 6;
      x1    = x0 + int'($urandom_range(2 * reach)) - reach;
      y1    = y0 + int'($urandom_range(2 * reach)) - reach;
    end else if (pick < 92) begin
      x0 = $urandom_range(1) ? 16383 - int'($urandom_range(6)) : -16384 + int'($urandom_range(6));
      y0 = $urandom_range(1) ? 16383 - int'($urandom_range(6)) : -16384 + int'($urandom_range(6));
      x1 = x0 + int'($urandom_range(12)) - 6;
      y1 = y0 + int'($urandom_range(12)) - 6;
    end else begin
      x0 = int'($urandom_range(32767)) - 16384;
      y0 = int'($urandom_range(32767)) - 16384;
      x1 = int'($urandom_range(32767)) - 16384;
      y1 = int'($urandom_range(32767)) - 16384;
    end
    x0  = clamp_coord(x0);
    y0  = clamp_coord(y0);
    x1  = clamp_coord(x1);
    y1  = clamp_coord(y1);
    len = line_length(x0, y0, x1, y1);
    // Usually the whole line plus up to two steps past its end; sometimes the
    // line is abandoned partway.
    if (pick >= 92 || $urandom_range(7) == 0)
      n = $urandom_range((len < 24) ? len : 24);
    else
      n = len + $urandom_range(2);
    queue_line(x0, y0, x1, y1, $urandom_range(16'hFFFF), n);
  endtask

  // Wait until every queued word is taken and every due pixel has arrived.
  // The check runs at the rising edge, where the driver's outputs are settled.
  // Then give the two-stage pipeline time to drain, because a trailing step
  // word yields nothing.
  task automatic settle();
    while (draw_q.size() != 0 || in_tvalid || pixels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both screen registers; the block must be idle.
  task automatic write_screen(int w, int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SCREEN_WIDTH;
    cfg_wdata <= SCREEN_W'(w);
    scr_w      = SCREEN_W'(w);
    @(negedge clk);
    cfg_addr  <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= SCREEN_W'(h);
    scr_h      = SCREEN_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(int w, int h, int idle, int stall, int n_items);
    settle();
    write_screen(w, h);
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    items_queued  = 0;
    while (items_queued < n_items)
      queue_random_line();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, with the screen at its reset size.
    // A step before any line exists must produce nothing.
    queue_line(0, 0, 0, 0, 16'h1234, 0);
    draw_q.delete();
    begin : lone_step
      draw_word_t w;
      w = '{mode: MODE_STEP, xs: 0, ys: 0, xe: 0, ye: 0, color: 0};
      draw_q.push_back(w);
    end
    // Single-point line, then a step past its end.
    queue_line(5, 5, 5, 5, 16'hA5A5, 1);
    // Field extremes: a full-range diagonal, abandoned after two steps.
    queue_line(-16384, 16383, 16383, -16384, 16'hFFFF, 2);
    // A new start while the long line is still running.
    queue_line(0, 0, 3, -2, 16'h0000, 4);
    // Horizontal and vertical lines, both endpoints drawn; the vertical one
    // is given in falling order.
    queue_line(0, 5, 4, 5, 16'h07E0, 4);
    queue_line(3, 7, 3, 3, 16'hF800, 4);
    // Crossing the lower right corner of the screen.
    queue_line(318, 478, 321, 481, 16'h001F, 3);

    // Random phases, each with its own screen size and a traffic pattern.
    run_phase(16383, 16383, 0, 0, 240);
    run_phase(1, 1, 50, 0, 240);
    run_phase(0, 0, 0, 50, 240);
    run_phase($urandom_range(1, 400), $urandom_range(1, 600), 22, 22, 240);
    run_phase(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 0, 0, 240);
    settle();

    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("line_rasterizer test passed");
    end else begin
      if (pixels_due.size() != 0)
        $display("%0d pixels never arrived", pixels_due.size());
      $display("line_rasterizer test failed");
    end
    $finish;
  end

endmodule
